// ===== design/sfbq_pkg.sv =====
package sfbq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned ModelW     = 8;
  localparam int unsigned TimeW      = 8;
  localparam int unsigned OccW       = 5;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned AgeCntW    = 8;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned RegIdxW    = AddrW - 2;
  localparam int unsigned DataW      = 32;

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(2);
  localparam logic [RegIdxW-1:0] RegAgingPeriod = RegIdxW'(0);

  typedef enum logic {
    OpInsert = 1'b0,
    OpTick   = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    CmdHold,
    CmdInsert,
    CmdAge,
    CmdShift,
    CmdDecHead
  } cell_cmd_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_cmd_e            op;
    logic [ModelW-1:0]    model;
    logic [TimeW-1:0]     key_time;
  } cell_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                 valid;
    logic [ModelW-1:0]    model;
    logic [TimeW-1:0]     tm;
    logic                 goes_after;
  } cell_link_t;

endpackage

// ===== design/sfbq_if.sv =====
interface sfbq_in_if;
  import sfbq_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ModelW-1:0] job_model;
  logic [TimeW-1:0]  job_time;

  modport source (output valid, output opcode, output job_model, output job_time,
                  input ready);
  modport sink   (input valid, input opcode, input job_model, input job_time,
                  output ready);
endinterface

interface sfbq_out_if;
  import sfbq_pkg::*;

  logic              valid;
  logic              ready;
  logic              completed;
  logic [ModelW-1:0] completed_model;
  logic              insert_rejected;
  logic [OccW-1:0]   occupancy;

  modport source (output valid, output completed, output completed_model,
                  output insert_rejected, output occupancy, input ready);
  modport sink   (input valid, input completed, input completed_model,
                  input insert_rejected, input occupancy, output ready);
endinterface

// ===== design/sfbq_cell.sv =====
module sfbq_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  first_i,
  input  sfbq_pkg::cell_ctl_t   ctl_i,
  input  sfbq_pkg::cell_link_t  prev_i,
  input  sfbq_pkg::cell_link_t  next_i,
  output sfbq_pkg::cell_link_t  link_o
);
  import sfbq_pkg::*;

  logic              valid_q, valid_d;
  logic [ModelW-1:0] model_q, model_d;
  logic [TimeW-1:0]  tm_q, tm_d;
  logic              goes_after;

  // Entries at or below the key stay put; the new entry lands at the boundary.
  assign goes_after = valid_q && (tm_q <= ctl_i.key_time);

  always_comb begin
    valid_d = valid_q;
    model_d = model_q;
    tm_d    = tm_q;
    unique case (ctl_i.op)
      CmdInsert, CmdAge: begin
        // re-sort only moves cells up to the aged one
        if ((ctl_i.op == CmdInsert || valid_q) && !goes_after) begin
          if (prev_i.goes_after) begin
            valid_d = 1'b1;
            model_d = ctl_i.model;
            tm_d    = ctl_i.key_time;
          end else begin
            valid_d = prev_i.valid;
            model_d = prev_i.model;
            tm_d    = prev_i.tm;
          end
        end
      end
      CmdShift: begin
        valid_d = next_i.valid;
        model_d = next_i.model;
        tm_d    = next_i.tm;
      end
      CmdDecHead: begin
        if (first_i) begin
          tm_d = tm_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    model_q <= model_d;
    tm_q    <= tm_d;
  end

  assign link_o = '{valid: valid_q, model: model_q, tm: tm_q, goes_after: goes_after};

endmodule

// ===== design/shortest_first_build_queue_with_aging.sv =====
// An accepted input transaction's result is registered and shows on out_o in the next cycle.
// Throughput: one transaction per cycle while out_o is not stalled; each item updates
// the whole cell row at once, and the output register frees as soon as out_o is taken.
// Reset: queue empty, aging counter zero, aging_period 2; cell payload is not
// cleared, only the per-cell valid bits.
module shortest_first_build_queue_with_aging (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sfbq_in_if.sink                      in_i,
  sfbq_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfbq_pkg::AddrW-1:0]   paddr,
  input  logic [sfbq_pkg::DataW-1:0]   pwdata,
  output logic [sfbq_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import sfbq_pkg::*;

  cell_link_t links      [QueueDepth];
  cell_link_t prev_links [QueueDepth];
  cell_link_t next_links [QueueDepth];
  cell_ctl_t  ctl;

  logic [CountW-1:0]  count_q, count_d;
  logic [AgeCntW-1:0] age_q, age_d;
  logic [PeriodW-1:0] period_q;

  logic               out_valid_q;
  logic               done_q, done_d;
  logic [ModelW-1:0]  done_model_q, done_model_d;
  logic               rejected_q, rejected_d;
  logic [OccW-1:0]    occ_q;

  logic               in_fire;
  logic               full;
  logic [ModelW-1:0]  last_model;
  logic [TimeW-1:0]   last_tm;
  logic [TimeW-1:0]   age_tm;
  logic [QueueDepth-1:0] valid_vec;
  logic [QueueDepth-1:0] sorted_vec;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_links[i] = '{valid: 1'b1, model: '0, tm: '0, goes_after: 1'b1};
    end else begin : g_mid
      assign prev_links[i] = links[i-1];
    end
    if (i == QueueDepth - 1) begin : g_tail
      assign next_links[i] = '0;
    end else begin : g_body
      assign next_links[i] = links[i+1];
    end

    sfbq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .first_i(1'(i == 0)),
      .ctl_i  (ctl),
      .prev_i (prev_links[i]),
      .next_i (next_links[i]),
      .link_o (links[i])
    );

    assign valid_vec[i]  = links[i].valid;
    assign sorted_vec[i] = !next_links[i].valid || (links[i].tm <= next_links[i].tm);
  end

  // Longest job sits in the last valid cell.
  always_comb begin
    last_model = '0;
    last_tm    = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (links[i].valid && !next_links[i].valid) begin
        last_model = last_model | links[i].model;
        last_tm    = last_tm | links[i].tm;
      end
    end
  end

  assign age_tm  = (last_tm == '0) ? '0 : last_tm - 1'b1;
  assign full    = (count_q == CountW'(QueueDepth));
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------- control
  always_comb begin
    ctl          = '{op: CmdHold, model: in_i.job_model, key_time: in_i.job_time};
    count_d      = count_q;
    age_d        = age_q;
    done_d       = 1'b0;
    done_model_d = '0;
    rejected_d   = 1'b0;
    if (in_fire) begin
      if (opcode_e'(in_i.opcode) == OpInsert) begin
        if (full) begin
          rejected_d = 1'b1;
        end else begin
          ctl.op  = CmdInsert;
          count_d = count_q + 1'b1;
        end
      end else begin
        priority if (count_q == '0) begin
          if (age_q != '1) age_d = age_q + 1'b1;
        end else if (age_q >= period_q && count_q > CountW'(1)) begin
          ctl.op       = CmdAge;
          ctl.model    = last_model;
          ctl.key_time = age_tm;
          age_d        = '0;
        end else if (links[0].tm <= TimeW'(1)) begin
          ctl.op       = CmdShift;
          done_d       = 1'b1;
          done_model_d = links[0].model;
          count_d      = count_q - 1'b1;
        end else begin
          ctl.op = CmdDecHead;
          if (age_q != '1) age_d = age_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      age_q       <= '0;
      period_q    <= PeriodReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      age_q   <= age_d;
      if (psel && penable && pwrite && pready &&
          paddr[AddrW-1:2] == RegAgingPeriod) begin
        period_q <= pwdata[PeriodW-1:0];
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      done_q       <= done_d;
      done_model_q <= done_model_d;
      rejected_q   <= rejected_d;
      occ_q        <= OccW'(count_d);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.completed       = done_q;
  assign out_o.completed_model = done_model_q;
  assign out_o.insert_rejected = rejected_q;
  assign out_o.occupancy       = occ_q;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1:2] == RegAgingPeriod) ? DataW'(period_q) : '0;

  // ---------------------------------------------------------------- checks
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountW'($countones(valid_vec)))
    else $error("job count disagrees with occupied cells");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &sorted_vec)
    else $error("queue lost its ordering by remaining time");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_e'(in_i.opcode) == OpInsert && !full)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not add a job");

endmodule
